/* rtl/length_prefixed_frame_decoder_macros.svh */
// assertion macros for the length-prefixed frame decoder checker
`ifndef LENGTH_PREFIXED_FRAME_DECODER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LPFD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpfd check failed");

// next-cycle implication, sampled on clk, off during reset
`define LPFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lpfd check failed");

`endif

/* rtl/lpfd_pkg.sv */
// shared types and constants of the length-prefixed frame decoder
package lpfd_pkg;

	// result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// header position codes
	localparam logic [2:0] HC_TYPE    = 3'd0;
	localparam logic [2:0] HC_LEN_B3  = 3'd1;
	localparam logic [2:0] HC_LEN_B2  = 3'd2;
	localparam logic [2:0] HC_LEN_B1  = 3'd3;
	localparam logic [2:0] HC_LEN_B0  = 3'd4;
	localparam logic [2:0] HC_PAYLOAD = 3'd5;

	// configuration
	localparam int          PADDR_W        = 3;
	localparam logic        REG_MAX_LEN    = 1'b0;
	localparam logic [31:0] MAX_LEN_RESET  = 32'd4096;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] frame_type;
		logic [7:0] payload_byte;
		logic       last;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} push_t;

	typedef struct packed {
		logic    not_empty;
		result_t data;
	} head_t;

endpackage

/* rtl/length_prefixed_frame_decoder.sv */
// top level of the length-prefixed frame decoder
// Decodes a byte stream of frames, each a type byte, a 32-bit big-endian
// length and that many payload bytes. Every payload byte leaves as one word
// of kind data, tagged with the frame type, the final one with last set. A
// zero length gives one empty-frame word, a length above max_payload_length
// (APB register at byte address 0, reset 4096) gives one error word and the
// decoder then drops input up to and including the next byte flagged
// end_of_chunk. Header bytes and dropped bytes give no word. Throughput is
// one byte per clock while in_stall is low: the front part updates all
// decoder state for each accepted byte. Each word is written into the queue
// when its byte is accepted, and the output register loads it from the
// queue head once the register is empty or its word leaves. A four-word
// queue lets input keep flowing while the output is stalled; in_stall rises
// only when that queue is full.
module length_prefixed_frame_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	input  logic                          end_of_chunk,
	// result stream
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    kind,
	output logic [7:0]                    frame_type,
	output logic [7:0]                    payload_byte,
	output logic                          last,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lpfd_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import lpfd_pkg::*;

	logic        max_len_wr;
	logic [31:0] max_len_q;
	logic        in_accept;
	logic        q_full;
	logic        q_pop;
	push_t       front_push;
	head_t       q_head;
	result_t     out_data;

	// config register, address bit 2 picks the register slot
	assign pready     = 1'b1;
	assign max_len_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_MAX_LEN);
	assign prdata     = (paddr[PADDR_W-1] == REG_MAX_LEN) ? max_len_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (max_len_wr) begin
			max_len_q <= pwdata;
		end
	end

	// input is held off only by a full queue
	assign in_stall  = q_full;
	assign in_accept = in_valid && !q_full;

	// header parse and classification, at most one word per byte
	lpfd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_accept),
		.in_byte      (in_byte),
		.end_of_chunk (end_of_chunk),
		.max_len      (max_len_q),
		.push         (front_push)
	);

	// decouples the parser from output back-pressure
	lpfd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.pop    (q_pop),
		.head   (q_head),
		.full   (q_full)
	);

	// registered output stage
	lpfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.pop       (q_pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	assign kind         = out_data.kind;
	assign frame_type   = out_data.frame_type;
	assign payload_byte = out_data.payload_byte;
	assign last         = out_data.last;

endmodule

/* rtl/lpfd_front.sv */
// front part: header parsing, length check and payload tagging
module lpfd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       in_byte,
	input  logic             end_of_chunk,
	input  logic [31:0]      max_len,
	output lpfd_pkg::push_t  push
);
	import lpfd_pkg::*;

	logic [2:0]  hdr_cnt_q, hdr_cnt_n;
	logic [7:0]  type_q, type_n;
	logic [31:0] len_q, len_n;     // header length, then payload bytes still due
	logic        discard_q, discard_n;
	logic [31:0] len_full;

	assign len_full = {len_q[23:0], in_byte};

	always_comb begin
		hdr_cnt_n = hdr_cnt_q;
		type_n    = type_q;
		len_n     = len_q;
		discard_n = discard_q;
		push.valid = 1'b0;
		push.data.kind         = KIND_DATA;
		push.data.frame_type   = type_q;
		push.data.payload_byte = 8'd0;
		push.data.last         = 1'b1;
		if (accept) begin
			if (discard_q) begin
				if (end_of_chunk) begin
					discard_n = 1'b0;
				end
			end else begin
				case (hdr_cnt_q) inside
					HC_TYPE: begin
						type_n    = in_byte;
						hdr_cnt_n = HC_LEN_B3;
					end
					HC_LEN_B3: begin
						len_n     = {24'd0, in_byte};
						hdr_cnt_n = HC_LEN_B2;
					end
					HC_LEN_B2, HC_LEN_B1: begin
						len_n     = len_full;
						hdr_cnt_n = hdr_cnt_q + 3'd1;
					end
					HC_LEN_B0: begin
						if (len_full > max_len) begin
							push.valid     = 1'b1;
							push.data.kind = KIND_ERROR;
							hdr_cnt_n      = HC_TYPE;
							len_n          = 32'd0;
							discard_n      = !end_of_chunk;
						end else if (len_full == 32'd0) begin
							push.valid     = 1'b1;
							push.data.kind = KIND_EMPTY;
							hdr_cnt_n      = HC_TYPE;
							len_n          = 32'd0;
						end else begin
							len_n     = len_full;
							hdr_cnt_n = HC_PAYLOAD;
						end
					end
					default: begin
						// payload phase, unreachable codes behave the same
						push.valid             = 1'b1;
						push.data.payload_byte = in_byte;
						push.data.last         = (len_q == 32'd1);
						if (len_q == 32'd1) begin
							hdr_cnt_n = HC_TYPE;
							len_n     = 32'd0;
						end else begin
							len_n = len_q - 32'd1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= HC_TYPE;
			type_q    <= 8'd0;
			len_q     <= 32'd0;
			discard_q <= 1'b0;
		end else begin
			hdr_cnt_q <= hdr_cnt_n;
			type_q    <= type_n;
			len_q     <= len_n;
			discard_q <= discard_n;
		end
	end

endmodule

/* rtl/lpfd_queue.sv */
// short result queue between the front and back parts
module lpfd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  lpfd_pkg::push_t  push,
	input  logic             pop,
	output lpfd_pkg::head_t  head,
	output logic             full
);
	import lpfd_pkg::*;

	result_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full           = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.not_empty = (count_q != '0);
	assign head.data      = entry_q[rd_ptr_q];
	assign do_push        = push.valid && !full;
	assign do_pop         = pop && head.not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/lpfd_back.sv */
// back part: output register that hands results to the consumer
module lpfd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  lpfd_pkg::head_t  head,
	output logic             pop,
	input  logic             out_stall,
	output logic             out_valid,
	output lpfd_pkg::result_t out_data
);
	import lpfd_pkg::*;

	logic    valid_q;
	result_t data_q;

	// refill when the register is empty or its word leaves this cycle
	assign pop       = head.not_empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

/* rtl/lpfd_checker.sv */
// port-level checks of the length-prefixed frame decoder and their binding
`include "length_prefixed_frame_decoder_macros.svh"

module lpfd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [1:0]                    kind,
	input logic [7:0]                    frame_type,
	input logic [7:0]                    payload_byte,
	input logic                          last
);
	import lpfd_pkg::*;

	logic [18:0] out_word;

	assign out_word = {kind, frame_type, payload_byte, last};

	// only the three defined kinds ever leave
	`LPFD_ASSERT_IMPL(a_kind_known, out_valid, kind != 2'd3)
	// empty-frame and error words always close the frame
	`LPFD_ASSERT_IMPL(a_ctrl_last, out_valid && (kind == KIND_EMPTY || kind == KIND_ERROR), last)
	// non-data words carry a zero data byte
	`LPFD_ASSERT_IMPL(a_ctrl_zero, out_valid && kind != KIND_DATA, payload_byte == 8'd0)
	// a stalled word stays put
	`LPFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

endmodule

bind length_prefixed_frame_decoder lpfd_checker u_lpfd_checker (.*);
